// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed: next cycle");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- sv/plc_pkg.sv -----
// Types, constants and arithmetic helpers of the partition LBA to CHS translator.
`default_nettype none
package plc_pkg;

    localparam int MAX_DRIVES           = 2;
    localparam int PARTITIONS_PER_DRIVE = 64;

    localparam int DIV_BITS   = 32;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

    localparam logic [7:0] DH_BASE    = 8'hA0;
    localparam logic [7:0] HEAD_LIMIT = 8'd15;

    localparam logic [2:0] CFG_DRIVE_COUNT = 3'd0;
    localparam logic [2:0] CFG_SPT_A       = 3'd1;
    localparam logic [2:0] CFG_HEADS_A     = 3'd2;
    localparam logic [2:0] CFG_SPT_B       = 3'd3;
    localparam logic [2:0] CFG_HEADS_B     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_HEAD     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [6:0]  minor_number;
        logic [31:0] sector_in_partition;
        logic [31:0] partition_start;
        logic [31:0] partition_size;
        logic [7:0]  sector_count;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  sector_number;
        logic [7:0]  head_number;
        logic [15:0] cylinder_number;
        logic        drive_number;
        logic [7:0]  drive_head_byte;
        logic [7:0]  count_out;
    } t_res;

    typedef struct packed {
        logic [1:0] drive_count;
        logic [7:0] spt_a;
        logic [7:0] heads_a;
        logic [7:0] spt_b;
        logic [7:0] heads_b;
    } t_cfg;

    typedef struct packed {
        logic [DIV_BITS-1:0] q;
        logic [7:0]          r;
        logic [7:0]          d;
    } t_div;

    typedef struct packed {
        t_status    status;
        logic       drive;
        logic [7:0] count;
        logic [7:0] heads;
        logic [7:0] sec;
        t_div       div;
    } t_stage;

    function automatic t_div plc_div_step(t_div x);
        t_div       y;
        logic [8:0] rr;
        rr  = {x.r, x.q[DIV_BITS-1]};
        y.d = x.d;
        y.q = {x.q[DIV_BITS-2:0], 1'b0};
        if (rr >= {1'b0, x.d}) begin
            rr     = rr - {1'b0, x.d};
            y.q[0] = 1'b1;
        end
        y.r = rr[7:0];
        return y;
    endfunction

    function automatic t_stage plc_remap(t_stage s);
        t_stage y;
        y       = s;
        y.sec   = s.div.r + 8'd1;
        y.div.q = s.div.q;
        y.div.r = '0;
        y.div.d = s.heads;
        return y;
    endfunction

endpackage
`default_nettype wire

// ----- sv/plc_chan_if.sv -----
// Valid/ready request channel carrying one payload of a chosen type.
`default_nettype none
interface plc_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/plc_check.sv -----
// Front stage: range checks, geometry select and absolute sector sum.
`default_nettype none
module plc_check import plc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    plc_chan_if.sink   i_up,
    plc_chan_if.source o_dn
);
    logic        drive;
    logic [5:0]  part;
    logic [32:0] sum;
    logic [7:0]  spt;
    logic [7:0]  heads;
    logic        absent;
    logic        ready;
    t_stage      n_data;
    t_stage      r_data;
    logic        r_valid;

    assign ready      = !r_valid || o_dn.ready;
    assign i_up.ready = ready;
    assign o_dn.valid = r_valid;
    assign o_dn.data  = r_data;

    always_comb begin
        drive  = i_up.data.minor_number[6];
        part   = i_up.data.minor_number[5:0];
        sum    = {1'b0, i_up.data.partition_start} + {1'b0, i_up.data.sector_in_partition};
        spt    = drive ? i_cfg.spt_b : i_cfg.spt_a;
        heads  = drive ? i_cfg.heads_b : i_cfg.heads_a;
        absent = ({1'b0, drive} >= i_cfg.drive_count)
              || (int'(drive) >= MAX_DRIVES)
              || (int'(part) >= PARTITIONS_PER_DRIVE)
              || (i_up.data.sector_in_partition >= i_up.data.partition_size);
        n_data.drive = drive;
        n_data.count = i_up.data.sector_count;
        n_data.heads = heads;
        n_data.sec   = '0;
        n_data.div.q = sum[DIV_BITS-1:0];
        n_data.div.r = '0;
        n_data.div.d = spt;
        priority if (absent) begin
            n_data.status = ST_RANGE;
        end else if (spt == 8'd0 || heads == 8'd0) begin
            n_data.status = ST_RANGE;
        end else if (sum[32]) begin
            n_data.status = ST_OVERFLOW;
        end else begin
            n_data.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_up.valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/plc_div_stage.sv -----
// One register stage of the restoring divider, several quotient bits per stage.
`default_nettype none
module plc_div_stage import plc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plc_chan_if.sink   i_up,
    plc_chan_if.source o_dn
);
    logic   ready;
    t_stage n_data;
    t_stage r_data;
    logic   r_valid;

    assign ready      = !r_valid || o_dn.ready;
    assign i_up.ready = ready;
    assign o_dn.valid = r_valid;
    assign o_dn.data  = r_data;

    always_comb begin
        n_data = i_up.data;
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_data.div = plc_div_step(n_data.div);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_up.valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/plc_format.sv -----
// Output stage: head and cylinder limits, task-file fields, result register.
`default_nettype none
module plc_format import plc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plc_chan_if.sink   i_up,
    plc_chan_if.source o_dn
);
    logic    ready;
    t_status st;
    t_res    n_data;
    t_res    r_data;
    logic    r_valid;

    assign ready      = !r_valid || o_dn.ready;
    assign i_up.ready = ready;
    assign o_dn.valid = r_valid;
    assign o_dn.data  = r_data;

    always_comb begin
        priority if (i_up.data.status != ST_OK) begin
            st = i_up.data.status;
        end else if (i_up.data.div.r > HEAD_LIMIT) begin
            st = ST_HEAD;
        end else if (i_up.data.div.q[DIV_BITS-1:16] != '0) begin
            st = ST_OVERFLOW;
        end else begin
            st = ST_OK;
        end
        n_data.status = st;
        if (st == ST_OK) begin
            n_data.sector_number   = i_up.data.sec;
            n_data.head_number     = i_up.data.div.r;
            n_data.cylinder_number = i_up.data.div.q[15:0];
            n_data.drive_number    = i_up.data.drive;
            n_data.drive_head_byte = DH_BASE | {3'b000, i_up.data.drive, 4'b0000}
                                   | i_up.data.div.r;
            n_data.count_out       = i_up.data.count;
        end else begin
            n_data.sector_number   = '0;
            n_data.head_number     = '0;
            n_data.cylinder_number = '0;
            n_data.drive_number    = 1'b0;
            n_data.drive_head_byte = '0;
            n_data.count_out       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_up.valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/partition_lba_to_chs.sv -----
// Partition sector to cylinder/head/sector translator, top level.
// Takes a request per cycle unless stalled; one check stage, two 32-bit restoring
// dividers (by sectors per track, then by heads) of four stages each at eight
// quotient bits per stage, and one output stage. Each stage holds its request while
// the next one is full, so bubbles close up under a stall. The user writes geometry
// and drive count through the configuration port only while idle; not enforced here.
`default_nettype none
`include "assert_macros.svh"
module partition_lba_to_chs import plc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    plc_chan_if.sink        i_req,
    plc_chan_if.source      o_res
);
    t_cfg r_cfg;

    plc_chan_if #(.T(t_stage)) l_spt   [DIV_STAGES+1] ();
    plc_chan_if #(.T(t_stage)) l_heads [DIV_STAGES+1] ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_count <= 2'd0;
            r_cfg.spt_a       <= 8'd17;
            r_cfg.heads_a     <= 8'd4;
            r_cfg.spt_b       <= 8'd17;
            r_cfg.heads_b     <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DRIVE_COUNT: r_cfg.drive_count <= i_cfg_data[1:0];
                CFG_SPT_A:       r_cfg.spt_a       <= i_cfg_data;
                CFG_HEADS_A:     r_cfg.heads_a     <= i_cfg_data;
                CFG_SPT_B:       r_cfg.spt_b       <= i_cfg_data;
                CFG_HEADS_B:     r_cfg.heads_b     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    plc_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_up    (i_req),
        .o_dn    (l_spt[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_spt
        plc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_up    (l_spt[g]),
            .o_dn    (l_spt[g+1])
        );
    end

    // hand remainder plus one to sector, quotient on to the head divider
    assign l_heads[0].valid         = l_spt[DIV_STAGES].valid;
    assign l_heads[0].data          = plc_remap(l_spt[DIV_STAGES].data);
    assign l_spt[DIV_STAGES].ready  = l_heads[0].ready;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_heads
        plc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_up    (l_heads[g]),
            .o_dn    (l_heads[g+1])
        );
    end

    plc_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_up    (l_heads[DIV_STAGES]),
        .o_dn    (o_res)
    );

    `ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, o_res.valid && o_res.data.status != ST_OK, o_res.data.sector_number == 8'd0 && o_res.data.drive_head_byte == 8'd0 && o_res.data.count_out == 8'd0)
    `ASSERT_IMPLIES(a_ok_fields, i_clk, i_rst_n, o_res.valid && o_res.data.status == ST_OK, o_res.data.sector_number != 8'd0 && o_res.data.head_number <= HEAD_LIMIT && o_res.data.drive_head_byte[7:5] == 3'b101)
    `ASSERT_IMPLIES(a_stall_full, i_clk, i_rst_n, !i_req.ready, o_res.valid && !o_res.ready)
endmodule
`default_nettype wire

// ----- tb/plc_chs_checker.sv -----
// Checker for the LBA to CHS translator: snoops config writes, predicts each request's result, compares.
module plc_chs_checker import plc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  t_req       i_req_data,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  t_res       i_res_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_mapped
);

    localparam t_cfg GEOM_RESET = '{2'd0, 8'd17, 8'd4, 8'd17, 8'd4};

    t_cfg geom;
    t_res chs_expected_q[$];

    function automatic t_res translate_lba(t_req r, t_cfg g);
        t_res        res;
        logic        drv;
        logic [7:0]  spt;
        logic [7:0]  hds;
        logic [32:0] abs_sec;
        logic [31:0] track;
        logic [31:0] head;
        logic [31:0] cyl;
        logic [31:0] sec;
        res     = '0;
        drv     = r.minor_number[6];
        spt     = drv ? g.spt_b : g.spt_a;
        hds     = drv ? g.heads_b : g.heads_a;
        abs_sec = {1'b0, r.partition_start} + {1'b0, r.sector_in_partition};
        if ({1'b0, drv} >= g.drive_count || int'(drv) >= MAX_DRIVES ||
            int'(r.minor_number[5:0]) >= PARTITIONS_PER_DRIVE ||
            r.sector_in_partition >= r.partition_size) begin
            res.status = ST_RANGE;
        end else if (spt == 8'd0 || hds == 8'd0) begin
            res.status = ST_RANGE;
        end else if (abs_sec[32]) begin
            res.status = ST_OVERFLOW;
        end else begin
            sec   = abs_sec[31:0] % {24'd0, spt};
            track = abs_sec[31:0] / {24'd0, spt};
            head  = track % {24'd0, hds};
            cyl   = track / {24'd0, hds};
            if (head > {24'd0, HEAD_LIMIT}) begin
                res.status = ST_HEAD;
            end else if (cyl > 32'hFFFF) begin
                res.status = ST_OVERFLOW;
            end else begin
                res.status          = ST_OK;
                res.sector_number   = sec[7:0] + 8'd1;
                res.head_number     = head[7:0];
                res.cylinder_number = cyl[15:0];
                res.drive_number    = drv;
                res.drive_head_byte = DH_BASE | {3'd0, drv, 4'd0} | head[7:0];
                res.count_out       = r.sector_count;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            geom = GEOM_RESET;
            chs_expected_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_mapped     = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (chs_expected_q.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none, got %h",
                             $time, i_res_data);
                    o_fail_count++;
                end else begin
                    want = chs_expected_q.pop_front();
                    check_field("status", want.status, i_res_data.status);
                    check_field("sector_number", want.sector_number,
                                i_res_data.sector_number);
                    check_field("head_number", want.head_number, i_res_data.head_number);
                    check_field("cylinder_number", want.cylinder_number,
                                i_res_data.cylinder_number);
                    check_field("drive_number", want.drive_number, i_res_data.drive_number);
                    check_field("drive_head_byte", want.drive_head_byte,
                                i_res_data.drive_head_byte);
                    check_field("count_out", want.count_out, i_res_data.count_out);
                    o_checked++;
                    if (want.status == ST_OK) o_mapped++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                chs_expected_q.push_back(translate_lba(i_req_data, geom));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DRIVE_COUNT: geom.drive_count = i_cfg_data[1:0];
                    CFG_SPT_A:       geom.spt_a       = i_cfg_data;
                    CFG_HEADS_A:     geom.heads_a     = i_cfg_data;
                    CFG_SPT_B:       geom.spt_b       = i_cfg_data;
                    CFG_HEADS_B:     geom.heads_b     = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = chs_expected_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the LBA to CHS translator: clock, reset, request and config stimulus, verdict.
module tb_top import plc_pkg::*; ();

    localparam logic [2:0] CFG_UNUSED_IDX = 3'd5;
    localparam int         HOLD_CYCLES    = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    int   fail_count;
    int   pending;
    int   checked;
    int   mapped;
    int   settings_run;
    t_cfg cfg_shadow;
    bit   tx_calm;
    bit   rx_calm;
    bit   squeeze_now;

    plc_chan_if #(.T(t_req)) req_ch ();
    plc_chan_if #(.T(t_res)) res_ch ();

    partition_lba_to_chs dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    plc_chs_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_data   (req_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_mapped     (mapped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_gap(input bit calm);
        if (calm || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic t_req pack_req(input logic [6:0] m, input logic [31:0] rel,
                                      input logic [31:0] st, input logic [31:0] sz,
                                      input logic [7:0] c);
        return '{m, rel, st, sz, c};
    endfunction

    function automatic t_req make_req(input bit shaped);
        t_req        r;
        logic [7:0]  spt;
        logic [7:0]  hds;
        logic [63:0] lim;
        logic [63:0] abs_sec;
        logic [63:0] size;
        r.minor_number        = 7'($urandom);
        r.sector_in_partition = $urandom;
        r.partition_start     = $urandom;
        r.partition_size      = $urandom;
        r.sector_count        = 8'($urandom);
        if (!shaped) return r;
        if (cfg_shadow.drive_count < 2'd2) r.minor_number[6] = 1'b0;
        spt = r.minor_number[6] ? cfg_shadow.spt_b : cfg_shadow.spt_a;
        hds = r.minor_number[6] ? cfg_shadow.heads_b : cfg_shadow.heads_a;
        lim = 64'd65536 * 64'(spt) * 64'(hds);
        if (lim == 64'd0 || lim > 64'h1_0000_0000) lim = 64'h1_0000_0000;
        case ($urandom_range(0, 7))
            0:       abs_sec = lim - 64'd1 + 64'($urandom_range(0, 1));
            1:       abs_sec = 64'($urandom_range(0, 255));
            default: abs_sec = 64'($urandom) % lim;
        endcase
        if (abs_sec > 64'hFFFF_FFFF) abs_sec = 64'hFFFF_FFFF;
        r.partition_start     = 32'(64'($urandom) % (abs_sec + 64'd1));
        r.sector_in_partition = 32'(abs_sec - 64'(r.partition_start));
        size = 64'(r.sector_in_partition) + 64'd1 + 64'($urandom_range(0, 1000));
        if ($urandom_range(0, 7) == 0) size = size + 64'($urandom);
        if (size > 64'hFFFF_FFFF) size = 64'hFFFF_FFFF;
        r.partition_size = 32'(size);
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_req(input t_req r);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n, input int squeeze_at);
        t_req r;
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            if (k == squeeze_at) squeeze_now = 1'b1;
            r = make_req($urandom_range(0, 3) != 0);
            send_req(r);
        end
        tx_calm = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
    endtask

    // drain the pipeline, then reprogram the geometry
    task automatic set_geometry(input logic [1:0] dc, input logic [7:0] sa,
                                input logic [7:0] ha, input logic [7:0] sb,
                                input logic [7:0] hb, input bit junk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        write_reg(CFG_DRIVE_COUNT, {6'd0, dc});
        write_reg(CFG_SPT_A, sa);
        write_reg(CFG_HEADS_A, ha);
        write_reg(CFG_SPT_B, sb);
        write_reg(CFG_HEADS_B, hb);
        if (junk) write_reg(CFG_UNUSED_IDX, 8'hFF);
        i_cfg_we   <= 1'b0;
        cfg_shadow = '{dc, sa, ha, sb, hb};
        settings_run++;
    endtask

    initial begin
        int gap;
        int taken;
        bit squeezed;
        res_ch.ready <= 1'b0;
        taken    = 0;
        squeezed = 1'b0;
        @(negedge i_clk);
        forever begin
            if (taken % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
            if (squeeze_now && !squeezed) begin
                squeezed = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            @(negedge i_clk);
            taken++;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_shadow   = '{2'd0, 8'd17, 8'd4, 8'd17, 8'd4};
        settings_run = 1;
        tx_calm      = 1'b0;
        squeeze_now  = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no drive present after reset
        send_req(pack_req(7'h00, 32'd0, 32'd0, 32'd1, 8'd0));
        send_req(pack_req(7'h40, 32'd0, 32'd0, 32'd1, 8'd255));
        send_random(120, -1);

        set_geometry(2'd2, 8'd17, 8'd4, 8'd63, 8'd16, 1'b0);
        send_req(pack_req(7'h00, 32'd0, 32'd0, 32'd1, 8'd255));
        send_req(pack_req(7'h7F, 32'd100, 32'd1000, 32'd101, 8'd1));
        send_req(pack_req(7'h3F, 32'd16, 32'd0, 32'd17, 8'd3));
        send_req(pack_req(7'h01, 32'd5, 32'd0, 32'd5, 8'd2));
        send_req(pack_req(7'h02, 32'd0, 32'd0, 32'd0, 8'd2));
        send_req(pack_req(7'h00, 32'd1, 32'hFFFF_FFFF, 32'd2, 8'd4));
        send_req(pack_req(7'h00, 32'd0, 32'hFFFF_FFFF, 32'd1, 8'd4));
        send_req(pack_req(7'h40, 32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFF, 8'd5));
        send_req(pack_req(7'h05, 32'd447, 32'd4456000, 32'd1000, 8'd6));
        send_req(pack_req(7'h05, 32'd448, 32'd4456000, 32'd1000, 8'd7));
        send_random(250, -1);

        set_geometry(2'd1, 8'd1, 8'd255, 8'd255, 8'd1, 1'b0);
        send_req(pack_req(7'h00, 32'd15, 32'd0, 32'd16, 8'd8));
        send_req(pack_req(7'h00, 32'd16, 32'd0, 32'd17, 8'd9));
        send_req(pack_req(7'h00, 32'd4, 32'd250, 32'd10, 8'd10));
        send_req(pack_req(7'h40, 32'd0, 32'd0, 32'd1, 8'd11));
        send_random(230, -1);

        set_geometry(2'd3, 8'd0, 8'd5, 8'd255, 8'd255, 1'b1);
        send_req(pack_req(7'h00, 32'd0, 32'd0, 32'd1, 8'd12));
        send_req(pack_req(7'h40, 32'd254, 32'd0, 32'd255, 8'd13));
        send_req(pack_req(7'h40, 32'd0, 32'hFFFF_FFFF, 32'd1, 8'd14));
        send_random(230, -1);

        set_geometry(2'd2, 8'd255, 8'd0, 8'd1, 8'd1, 1'b0);
        send_req(pack_req(7'h00, 32'd0, 32'd0, 32'd1, 8'd15));
        send_req(pack_req(7'h40, 32'd65535, 32'd0, 32'd65536, 8'd16));
        send_req(pack_req(7'h40, 32'd65536, 32'd0, 32'd65537, 8'd17));
        send_random(230, -1);

        set_geometry(2'd2, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 1'b0);
        send_random(320, 80);

        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Checked %0d translations under %0d drive settings: %0d mapped, %0d rejected or flagged.",
                 checked, settings_run, mapped, checked - mapped);
        $display("Receiver backed the pipeline up once for %0d cycles.", HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
